// ===== src/perfect_hash_keyword_matcher_assert.svh =====
// Assertion helpers for the matcher RTL.
`ifndef PERFECT_HASH_KEYWORD_MATCHER_ASSERT_SVH
`define PERFECT_HASH_KEYWORD_MATCHER_ASSERT_SVH

// Property that must hold at every enabled clock edge.
`define PHKM_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("phkm: invariant violated");

// Same-cycle implication.
`define PHKM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phkm: implication violated");

// Next-cycle implication.
`define PHKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phkm: next-cycle implication violated");

`endif

// ===== src/phkm_pkg.sv =====
`timescale 1ns / 1ps

package phkm_pkg;

    // Default sizing
    localparam int DEF_MAX_KEY_LENGTH = 11;
    localparam int DEF_TABLE_SLOTS    = 37;

    // Fixed field widths
    localparam int CHAR_W   = 8;
    localparam int SLOT_W   = 6;
    localparam int ID_W     = 5;
    localparam int HASH_W   = 6;
    localparam int KLEN_W   = 4;
    localparam int KW_CHARS = 11;

    // Length gate and hashed byte positions
    localparam int MIN_KEY_LENGTH = 3;
    localparam int WT_POS1        = 5;
    localparam int WT_POS2        = 7;

    // Shared unit operations
    typedef enum logic {
        OP_ADD,
        OP_CMP
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [CHAR_W-1:0]   a;
        logic [CHAR_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [CHAR_W-1:0]   result;
        logic                eq;
    } t_alu_rsp;

    typedef struct packed {
        logic                valid;
        logic [3:0]          weight;
    } t_weight;

    // Keyword slot: text is right-justified, first char in the highest used byte
    typedef struct packed {
        logic [KLEN_W-1:0]       klen;
        logic [ID_W-1:0]         id;
        logic [KW_CHARS*8-1:0]   text;
    } t_kw_entry;

    function automatic t_weight byte_weight(input logic [CHAR_W-1:0] c);
        t_weight w;
        w.valid  = 1'b1;
        w.weight = 4'd0;
        case (c)
            "I": w.weight = 4'd10;
            "M": w.weight = 4'd0;
            "a": w.weight = 4'd5;
            "b": w.weight = 4'd15;
            "c": w.weight = 4'd10;
            "d": w.weight = 4'd0;
            "f": w.weight = 4'd10;
            "g": w.weight = 4'd5;
            "i": w.weight = 4'd10;
            "l": w.weight = 4'd0;
            "n": w.weight = 4'd0;
            "o": w.weight = 4'd0;
            "r": w.weight = 4'd0;
            "s": w.weight = 4'd0;
            "t": w.weight = 4'd0;
            "u": w.weight = 4'd0;
            default: w.valid = 1'b0;
        endcase
        return w;
    endfunction

    function automatic t_kw_entry mk_kw(input logic [KLEN_W-1:0] l, input logic [ID_W-1:0] id,
                                        input logic [KW_CHARS*8-1:0] t);
        t_kw_entry e;
        e.klen = l;
        e.id   = id;
        e.text = t;
        return e;
    endfunction

    function automatic t_kw_entry kw_entry(input logic [HASH_W-1:0] slot);
        t_kw_entry e;
        e = '0;
        case (slot)
            6'd3:    e = mk_kw(4'd3,  5'd16, "url");
            6'd4:    e = mk_kw(4'd4,  5'd14, "size");
            6'd6:    e = mk_kw(4'd6,  5'd13, "target");
            6'd7:    e = mk_kw(4'd7,  5'd9,  "leading");
            6'd8:    e = mk_kw(4'd8,  5'd12, "tabStops");
            6'd9:    e = mk_kw(4'd9,  5'd15, "underline");
            6'd10:   e = mk_kw(4'd5,  5'd1,  "align");
            6'd11:   e = mk_kw(4'd11, 5'd11, "rightMargin");
            6'd14:   e = mk_kw(4'd4,  5'd6,  "font");
            6'd15:   e = mk_kw(4'd5,  5'd5,  "color");
            6'd16:   e = mk_kw(4'd6,  5'd7,  "indent");
            6'd19:   e = mk_kw(4'd4,  5'd3,  "bold");
            6'd20:   e = mk_kw(4'd10, 5'd10, "leftMargin");
            6'd21:   e = mk_kw(4'd6,  5'd4,  "bullet");
            6'd26:   e = mk_kw(4'd6,  5'd8,  "italic");
            6'd36:   e = mk_kw(4'd11, 5'd2,  "blockIndent");
            default: e = '0;
        endcase
        return e;
    endfunction

    // Character idx of a keyword, counted from its first character
    function automatic logic [CHAR_W-1:0] kw_byte(input t_kw_entry e, input logic [3:0] idx);
        int pos;
        pos = int'(e.klen) - 1 - int'(idx);
        if (pos < 0) begin
            return '0;
        end
        return e.text[8*pos +: 8];
    endfunction

endpackage

// ===== src/phkm_if.sv =====
`timescale 1ns / 1ps

// Character channel
interface phkm_char_if import phkm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// Result channel
interface phkm_res_if import phkm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   member_id;

    modport source (output valid, output found, output slot, output member_id, input ready);
    modport sink   (input valid, input found, input slot, input member_id, output ready);
endinterface

// ===== src/phkm_word_buf.sv =====
`timescale 1ns / 1ps

module phkm_word_buf import phkm_pkg::*; #(
    parameter int DEPTH = DEF_MAX_KEY_LENGTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [CHAR_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [CHAR_W-1:0]        o_rdata
);

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/phkm_alu.sv =====
`timescale 1ns / 1ps

module phkm_alu import phkm_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    // Shared adder / byte comparator
    always_comb begin
        unique case (i_req.op)
            OP_ADD: begin
                o_rsp.result = i_req.a + i_req.b;
                o_rsp.eq     = 1'b0;
            end
            OP_CMP: begin
                o_rsp.result = i_req.a ^ i_req.b;
                o_rsp.eq     = (i_req.a == i_req.b);
            end
            default: begin
                o_rsp.result = '0;
                o_rsp.eq     = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/phkm_engine.sv =====
`timescale 1ns / 1ps

`include "perfect_hash_keyword_matcher_assert.svh"

module phkm_engine import phkm_pkg::*; #(
    parameter int MAX_KEY_LENGTH = DEF_MAX_KEY_LENGTH,
    parameter int TABLE_SLOTS    = DEF_TABLE_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    phkm_char_if.sink                         i_chr,
    phkm_res_if.source                        o_res,
    output logic                              o_we,
    output logic [$clog2(MAX_KEY_LENGTH)-1:0] o_waddr,
    output logic [CHAR_W-1:0]                 o_wdata,
    output logic [$clog2(MAX_KEY_LENGTH)-1:0] o_raddr,
    input  logic [CHAR_W-1:0]                 i_rdata,
    output t_alu_req                          o_alu_req,
    input  t_alu_rsp                          i_alu_rsp
);

    localparam int IDX_W = $clog2(MAX_KEY_LENGTH);
    localparam int LEN_W = $clog2(MAX_KEY_LENGTH + 2);

    typedef enum logic [2:0] {
        S_COLLECT,
        S_WEIGHT,
        S_CHECK,
        S_CMP,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_flen, n_flen;
    logic [HASH_W-1:0]  r_hash, n_hash;
    logic               r_ok, n_ok;
    logic [1:0]         r_wsel, n_wsel;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_found, n_found;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [ID_W-1:0]    r_id, n_id;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic [ID_W-1:0]    r_out_id, n_out_id;

    logic               in_acc;
    logic [LEN_W-1:0]   len_inc;
    logic               more_wt;
    t_weight            wt;
    t_kw_entry          kw;

    assign in_acc  = i_chr.valid && i_chr.ready;
    assign len_inc = (r_len <= LEN_W'(MAX_KEY_LENGTH)) ? r_len + LEN_W'(1) : r_len;
    assign wt      = byte_weight(i_rdata);
    assign kw      = kw_entry(r_hash);
    assign more_wt = ((r_wsel == 2'd0) && (r_flen > LEN_W'(WT_POS1))) ||
                     ((r_wsel == 2'd1) && (r_flen > LEN_W'(WT_POS2)));

    // Buffer write on every accepted beat that still fits
    assign o_we    = in_acc && (r_len < LEN_W'(MAX_KEY_LENGTH));
    assign o_waddr = r_len[IDX_W-1:0];
    assign o_wdata = i_chr.char_code;

    assign i_chr.ready     = (r_state == S_COLLECT);
    assign o_res.valid     = r_out_valid;
    assign o_res.found     = r_out_found;
    assign o_res.slot      = r_out_slot;
    assign o_res.member_id = r_out_id;

    // Read address for the byte needed in the next cycle
    always_comb begin
        o_raddr = '0;
        unique case (r_state)
            S_WEIGHT: begin
                if (more_wt) begin
                    o_raddr = (r_wsel == 2'd0) ? IDX_W'(WT_POS1) : IDX_W'(WT_POS2);
                end
            end
            S_CMP:   o_raddr = r_idx + IDX_W'(1);
            default: o_raddr = '0;
        endcase
    end

    // Shared unit operands
    always_comb begin
        o_alu_req.op = OP_ADD;
        o_alu_req.a  = {{(CHAR_W-HASH_W){1'b0}}, r_hash};
        o_alu_req.b  = {4'd0, wt.weight};
        if (r_state == S_CMP) begin
            o_alu_req.op = OP_CMP;
            o_alu_req.a  = i_rdata;
            o_alu_req.b  = kw_byte(kw, 4'(r_idx));
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_flen      = r_flen;
        n_hash      = r_hash;
        n_ok        = r_ok;
        n_wsel      = r_wsel;
        n_idx       = r_idx;
        n_found     = r_found;
        n_slot      = r_slot;
        n_id        = r_id;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_slot  = r_out_slot;
        n_out_id    = r_out_id;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_COLLECT: begin
                if (in_acc) begin
                    n_len = len_inc;
                    if (i_chr.last_char) begin
                        n_len   = '0;
                        n_flen  = len_inc;
                        n_hash  = HASH_W'(len_inc);
                        n_ok    = 1'b1;
                        n_wsel  = 2'd0;
                        n_found = 1'b0;
                        n_slot  = '0;
                        n_id    = '0;
                        if ((len_inc < LEN_W'(MIN_KEY_LENGTH)) ||
                            (len_inc > LEN_W'(MAX_KEY_LENGTH))) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_WEIGHT;
                        end
                    end
                end
            end
            S_WEIGHT: begin
                n_hash = i_alu_rsp.result[HASH_W-1:0];
                n_ok   = r_ok && wt.valid;
                if (more_wt) begin
                    n_wsel = r_wsel + 2'd1;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx = '0;
                if (!r_ok || ({1'b0, r_hash} >= 7'(TABLE_SLOTS)) ||
                    (8'(kw.klen) != 8'(r_flen))) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_alu_rsp.eq) begin
                    n_state = S_EMIT;
                end else if (8'(r_idx) == 8'(kw.klen) - 8'd1) begin
                    n_found = 1'b1;
                    n_slot  = r_hash;
                    n_id    = kw.id;
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_slot  = r_slot;
                    n_out_id    = r_id;
                    n_state     = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_flen      <= n_flen;
        r_hash      <= n_hash;
        r_ok        <= n_ok;
        r_wsel      <= n_wsel;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_id        <= n_id;
        r_out_found <= n_out_found;
        r_out_slot  <= n_out_slot;
        r_out_id    <= n_out_id;
    end

    // Checks
    `PHKM_ASSERT_ALWAYS(a_len_sat, i_clk, i_rst_n, r_len <= LEN_W'(MAX_KEY_LENGTH + 1))
    `PHKM_ASSERT_NEXT(a_len_clr, i_clk, i_rst_n, in_acc && i_chr.last_char, r_len == '0)
    `PHKM_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, r_out_valid && r_out_found,
        ({1'b0, r_out_slot} < 7'(TABLE_SLOTS)) && (r_out_id != '0))
    `PHKM_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_out_found,
        (r_out_slot == '0) && (r_out_id == '0))
    `PHKM_ASSERT_NEXT(a_emit_load, i_clk, i_rst_n,
        (r_state == S_EMIT) && (!r_out_valid || o_res.ready),
        r_out_valid && (r_state == S_COLLECT))

endmodule

// ===== src/perfect_hash_keyword_matcher.sv =====
`timescale 1ns / 1ps

// Keyword matcher: a word arrives on i_chr one byte per beat, last_char set
// on its final byte. Every final byte yields exactly one beat on o_res with
// found, slot and member_id (slot and member_id are zero on a miss).
// Non-final bytes are taken one per cycle. After the final byte the
// sequencer runs the shared add/compare unit against the word buffer, one
// buffer read per cycle: 1 to 3 weight steps, one slot check, then one byte
// compare per keyword character. A length reject goes straight to the
// result. i_chr.ready stays low until the result is loaded into the
// output register. A finished result sits in the output register; the
// next word is taken while it waits, and the sequencer holds its next
// result until o_res drains. Synchronous active-low reset empties the
// output register and clears the length count; the word buffer needs no
// clearing.
module perfect_hash_keyword_matcher import phkm_pkg::*; #(
    parameter int MAX_KEY_LENGTH = DEF_MAX_KEY_LENGTH,
    parameter int TABLE_SLOTS    = DEF_TABLE_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phkm_char_if.sink   i_chr,
    phkm_res_if.source  o_res
);

    localparam int IDX_W = $clog2(MAX_KEY_LENGTH);

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CHAR_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
    logic [CHAR_W-1:0] rdata;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;

    phkm_engine #(
        .MAX_KEY_LENGTH (MAX_KEY_LENGTH),
        .TABLE_SLOTS    (TABLE_SLOTS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_chr     (i_chr),
        .o_res     (o_res),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_alu_req (alu_req),
        .i_alu_rsp (alu_rsp)
    );

    phkm_word_buf #(
        .DEPTH (MAX_KEY_LENGTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    phkm_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

endmodule

// ===== tb/sv/phkm_match_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the keyword matcher, predicts one result per word
// and compares every result beat against the oldest prediction.
module phkm_match_checker import phkm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    phkm_char_if  i_chr,
    phkm_res_if   i_res,
    output int    o_mismatches,
    output int    o_pending
);

    localparam int MAX_LEN = DEF_MAX_KEY_LENGTH;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   member_id;
    } t_match;

    // Predictor state: buffered word and its saturating length
    logic [CHAR_W-1:0] word_buf [MAX_LEN];
    int                word_len;
    t_match            match_q [$];
    int                mismatches;

    // Hash weight per byte; -1 marks a byte with no weight, which rules out a keyword hash
    function automatic int char_weight(input logic [CHAR_W-1:0] c);
        case (c)
            "I", "c", "f", "i":                          return 10;
            "a", "g":                                    return 5;
            "b":                                         return 15;
            "M", "d", "l", "n", "o", "r", "s", "t", "u": return 0;
            default:                                     return -1;
        endcase
    endfunction

    // Keyword stored in each hash slot; empty text means an unused slot
    function automatic void keyword_at(input int s, output string text,
                                       output logic [ID_W-1:0] id);
        text = "";
        id   = '0;
        case (s)
            3:  begin text = "url";         id = 16; end
            4:  begin text = "size";        id = 14; end
            6:  begin text = "target";      id = 13; end
            7:  begin text = "leading";     id = 9;  end
            8:  begin text = "tabStops";    id = 12; end
            9:  begin text = "underline";   id = 15; end
            10: begin text = "align";       id = 1;  end
            11: begin text = "rightMargin"; id = 11; end
            14: begin text = "font";        id = 6;  end
            15: begin text = "color";       id = 5;  end
            16: begin text = "indent";      id = 7;  end
            19: begin text = "bold";        id = 3;  end
            20: begin text = "leftMargin";  id = 10; end
            21: begin text = "bullet";      id = 4;  end
            26: begin text = "italic";      id = 8;  end
            36: begin text = "blockIndent"; id = 2;  end
            default: ;
        endcase
    endfunction

    // Expected result for the word now in the buffer
    function automatic t_match predict_match(input int len);
        t_match          m;
        int              w;
        int              hash;
        bit              weighted;
        string           kw;
        logic [ID_W-1:0] kid;
        m = '0;
        if (len < MIN_KEY_LENGTH || len > MAX_LEN) begin
            return m;
        end
        w        = char_weight(word_buf[0]);
        weighted = (w >= 0);
        hash     = len + w;
        if (len > WT_POS1) begin
            w        = char_weight(word_buf[WT_POS1]);
            weighted = weighted && (w >= 0);
            hash     = hash + w;
        end
        if (len > WT_POS2) begin
            w        = char_weight(word_buf[WT_POS2]);
            weighted = weighted && (w >= 0);
            hash     = hash + w;
        end
        if (!weighted || hash >= DEF_TABLE_SLOTS) begin
            return m;
        end
        keyword_at(hash, kw, kid);
        if (kw.len() != len) begin
            return m;
        end
        for (int i = 0; i < len; i++) begin
            if (word_buf[i] != kw[i]) begin
                return m;
            end
        end
        m.found     = 1'b1;
        m.slot      = hash[SLOT_W-1:0];
        m.member_id = kid;
        return m;
    endfunction

    task automatic log_mismatch(input string what, input t_match want, input t_match got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected found=%0b slot=%0d member=%0d", $realtime, what,
                     want.found, want.slot, want.member_id);
            $display("%0t: %s:      got found=%0b slot=%0d member=%0d", $realtime, what,
                     got.found, got.slot, got.member_id);
        end
    endtask

    // Sample both channels at the edge, predict on char beats, check result beats
    always @(posedge i_clk) begin
        t_match got;
        t_match want;
        if (!i_rst_n) begin
            word_len = 0;
            match_q.delete();
        end else begin
            if (i_chr.valid && i_chr.ready) begin
                if (word_len < MAX_LEN) begin
                    word_buf[word_len] = i_chr.char_code;
                end
                if (word_len <= MAX_LEN) begin
                    word_len++;
                end
                if (i_chr.last_char) begin
                    match_q.push_back(predict_match(word_len));
                    word_len = 0;
                end
            end
            if (i_res.valid && i_res.ready) begin
                got.found     = i_res.found;
                got.slot      = i_res.slot;
                got.member_id = i_res.member_id;
                if (match_q.size() == 0) begin
                    log_mismatch("result beat with no word pending", '0, got);
                end else begin
                    want = match_q.pop_front();
                    if (got.found !== want.found || got.slot !== want.slot ||
                        got.member_id !== want.member_id) begin
                        log_mismatch("keyword result mismatch", want, got);
                    end
                end
            end
        end
        o_pending    <= match_q.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== tb/sv/perfect_hash_keyword_matcher_tb.sv =====
`timescale 1ns / 1ps

module perfect_hash_keyword_matcher_tb;
    import phkm_pkg::*;

    localparam int TARGET_CHARS = 1500;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 40;

    typedef logic [CHAR_W-1:0] t_char_q [$];

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   cycles = 0;
    int   chars_sent = 0;
    int   res_hold = 0;
    bit   calm = 1'b0;

    string keywords [16] = '{"url", "size", "target", "leading", "tabStops", "underline",
                             "align", "rightMargin", "font", "color", "indent", "bold",
                             "leftMargin", "bullet", "italic", "blockIndent"};
    string weighted_chars = "IMabcdfgilnorstu";

    phkm_char_if chr_if ();
    phkm_res_if  res_if ();

    perfect_hash_keyword_matcher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (chr_if),
        .o_res   (res_if)
    );

    phkm_match_checker i_match_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chr        (chr_if),
        .i_res        (res_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long; none in calm stretches
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result sink stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (res_hold > 0) begin
            res_if.ready <= 1'b0;
            res_hold     <= res_hold - 1;
        end else begin
            res_if.ready <= 1'b1;
            res_hold     <= idle_len();
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("perfect_hash_keyword_matcher_tb: errors");
            $finish;
        end
    end

    function automatic t_char_q text_bytes(input string s);
        t_char_q q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    // Either a hash-relevant letter or any non-zero byte
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 1)) begin
            return weighted_chars[$urandom_range(0, weighted_chars.len() - 1)];
        end
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    // One char beat, with an optional idle gap ahead of it
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            chr_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        chr_if.valid     <= 1'b1;
        chr_if.char_code <= c;
        chr_if.last_char <= last;
        @(posedge i_clk);
        while (!chr_if.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_word(input t_char_q w);
        for (int i = 0; i < w.size(); i++) begin
            send_char(w[i], i == w.size() - 1);
        end
    endtask

    initial begin
        t_char_q word;
        int      kind;
        int      pos;
        chr_if.valid     <= 1'b0;
        chr_if.char_code <= '0;
        chr_if.last_char <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: shortest keyword, too short, slot hit with wrong text,
        // hash past the table, too long
        send_word(text_bytes("url"));
        send_word(text_bytes("q"));
        send_word(text_bytes("fonx"));
        send_word(text_bytes("bbbbbbbb"));
        send_word(text_bytes("zzzzzzzzzzzz"));

        // Random words, mostly keywords and near misses
        while (chars_sent < TARGET_CHARS) begin
            if ($urandom_range(0, 15) == 0) begin
                calm = !calm;
            end
            kind = $urandom_range(0, 99);
            word = text_bytes(keywords[$urandom_range(0, 15)]);
            if (kind < 45) begin
                // exact keyword
            end else if (kind < 65) begin
                pos       = $urandom_range(0, word.size() - 1);
                word[pos] = pick_char();
            end else if (kind < 75) begin
                if ($urandom_range(0, 1)) begin
                    void'(word.pop_back());
                end else begin
                    repeat ($urandom_range(1, 4)) word.push_back(pick_char());
                end
            end else if (kind < 88) begin
                // letters that all carry a weight, to spread over the slots
                word.delete();
                repeat ($urandom_range(3, 11)) begin
                    word.push_back(weighted_chars[$urandom_range(0, 15)]);
                end
            end else begin
                word.delete();
                repeat ($urandom_range(1, 16)) word.push_back(CHAR_W'($urandom_range(1, 255)));
            end
            send_word(word);
        end
        chr_if.valid <= 1'b0;

        // Drain and verdict; one edge first so the last word is counted as pending
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("perfect_hash_keyword_matcher_tb: clean");
        end else begin
            $display("perfect_hash_keyword_matcher_tb: errors");
        end
        $finish;
    end

endmodule
